>>> rtl/core/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg
// shared constants, widths and controller/datapath interface types for the
// idle state residency statistics core
// ----------------------------------------------------------------------------
`default_nettype none

package isr_pkg;

   localparam int CPU_COUNT   = 8;
   localparam int IDLE_STATES = 8;
   localparam int SLOT_COUNT  = CPU_COUNT * IDLE_STATES;
   localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int CPU_W   = 3;
   localparam int STATE_W = 3;
   localparam int TIME_W  = 48;
   localparam int CNT_W   = 32;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 280;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_EXIT  = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;        // capture the request beat
      logic ent_write;   // record an idle entry
      logic rd_issue;    // read the open slot
      logic calc;        // form the elapsed time
      logic upd;         // write back new statistics
      logic div_start;   // start the mean division
      logic out_load;    // move the result into the output register
   } isr_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_exit;
      logic cpu_ok;
      logic state_ok;
      logic open_ok;
      logic negative;
      logic div_done;
   } isr_sts_type;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [CPU_W-1:0]   cpu,
                                                 input logic [STATE_W-1:0] st);
      logic [SLOT_W+CPU_W+STATE_W-1:0] full;
      full = (SLOT_W+CPU_W+STATE_W)'(cpu) * (SLOT_W+CPU_W+STATE_W)'(IDLE_STATES)
             + (SLOT_W+CPU_W+STATE_W)'(st);
      return full[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/isr_div.sv
// ----------------------------------------------------------------------------
// isr_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module isr_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [isr_pkg::TIME_W-1:0] dividend,
   input  wire logic [isr_pkg::CNT_W-1:0]  divisor,
   output logic                            done,
   output logic [isr_pkg::TIME_W-1:0]      quotient
);
   import isr_pkg::*;

   localparam int STEP_W = $clog2(TIME_W + 1);

   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [TIME_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]      dsr_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W:0]        shifted;
   logic [CNT_W:0]        diff;

   // remainder stays below the divisor, so it fits in CNT_W bits
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (!diff[CNT_W]) begin
         rem_in = diff[CNT_W-1:0];
         quo_in = {quo_ff[TIME_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[CNT_W-1:0];
         quo_in = {quo_ff[TIME_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= STEP_W'(TIME_W);
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/isr_datapath.sv
// ----------------------------------------------------------------------------
// isr_datapath
// per-cpu open-state registers, entry time and statistics memories,
// statistics update and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module isr_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire isr_pkg::isr_cmd_type           cmd,
   output isr_pkg::isr_sts_type                sts,
   input  wire logic                           req_tuser,
   input  wire logic [isr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [isr_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import isr_pkg::*;

   localparam int ROW_W = CNT_W + 3 * TIME_W;

   // captured request
   logic                op_ff;
   logic [CPU_W-1:0]    cpu_ff;
   logic [STATE_W-1:0]  state_ff;
   logic [TIME_W-1:0]   ts_ff;

   // per-cpu state
   logic [STATE_W-1:0]  open_state_ff [CPU_COUNT];
   logic                open_valid_ff [CPU_COUNT];
   logic                ever_entered_ff [CPU_COUNT];

   // memories; row = {longest, shortest, total, count}
   logic [TIME_W-1:0]   entry_mem [SLOT_COUNT];
   logic [ROW_W-1:0]    stats_mem [SLOT_COUNT];
   logic                stats_valid_ff [SLOT_COUNT];

   logic [SLOT_W-1:0]   slot_ff;
   logic [STATE_W-1:0]  slot_state_ff;
   logic [TIME_W-1:0]   entry_rd_ff;
   logic [ROW_W-1:0]    stats_rd_ff;
   logic                stats_vld_rd_ff;

   logic [TIME_W:0]     elapsed_ff, elapsed_in;

   logic [CNT_W-1:0]    old_count;
   logic [TIME_W-1:0]   old_total, old_short, old_long;
   logic [CNT_W-1:0]    count_in;
   logic [TIME_W-1:0]   total_in, short_in, long_in;
   logic [TIME_W:0]     sum;

   // result being built
   logic [CPU_W-1:0]    res_cpu_ff;
   logic [STATE_W-1:0]  res_state_ff;
   logic [TIME_W-1:0]   res_interval_ff;
   logic [CNT_W-1:0]    res_count_ff;
   logic [TIME_W-1:0]   res_total_ff, res_short_ff, res_long_ff;

   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                div_done;
   logic [TIME_W-1:0]   quotient;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_tuser;
         cpu_ff   <= req_tdata[CPU_W-1:0];
         state_ff <= req_tdata[CPU_W+STATE_W-1:CPU_W];
         ts_ff    <= req_tdata[CPU_W+STATE_W+TIME_W-1:CPU_W+STATE_W];
      end
   end

   always_comb begin
      sts.is_exit  = (op_ff == OP_EXIT);
      sts.cpu_ok   = (32'(cpu_ff) < CPU_COUNT);
      sts.state_ok = (32'(state_ff) < IDLE_STATES);
      sts.open_ok  = ever_entered_ff[cpu_ff] && open_valid_ff[cpu_ff];
      sts.negative = elapsed_ff[TIME_W];
      sts.div_done = div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CPU_COUNT; i++) begin
            open_state_ff[i]   <= '0;
            open_valid_ff[i]   <= 1'b0;
            ever_entered_ff[i] <= 1'b0;
         end
      end else if (cmd.ent_write) begin
         open_state_ff[cpu_ff]   <= state_ff;
         open_valid_ff[cpu_ff]   <= 1'b1;
         ever_entered_ff[cpu_ff] <= 1'b1;
      end else if (cmd.upd) begin
         open_valid_ff[cpu_ff] <= 1'b0;
      end
   end

   // entry time memory
   always_ff @(posedge clock) begin
      if (cmd.ent_write) begin
         entry_mem[slot_of(cpu_ff, state_ff)] <= ts_ff;
      end
      if (cmd.rd_issue) begin
         entry_rd_ff <= entry_mem[slot_of(cpu_ff, open_state_ff[cpu_ff])];
      end
   end

   // statistics memory
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         stats_mem[slot_ff] <= {long_in, short_in, total_in, count_in};
      end
      if (cmd.rd_issue) begin
         stats_rd_ff <= stats_mem[slot_of(cpu_ff, open_state_ff[cpu_ff])];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            stats_valid_ff[i] <= 1'b0;
         end
      end else if (cmd.upd) begin
         stats_valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         slot_ff         <= slot_of(cpu_ff, open_state_ff[cpu_ff]);
         slot_state_ff   <= open_state_ff[cpu_ff];
         stats_vld_rd_ff <= stats_valid_ff[slot_of(cpu_ff, open_state_ff[cpu_ff])];
      end
   end

   // borrow bit marks an exit earlier than the entry
   assign elapsed_in = {1'b0, ts_ff} - {1'b0, entry_rd_ff};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         elapsed_ff <= elapsed_in;
      end
   end

   // never-written rows read as their reset values
   always_comb begin
      if (stats_vld_rd_ff) begin
         old_count = stats_rd_ff[CNT_W-1:0];
         old_total = stats_rd_ff[CNT_W+TIME_W-1:CNT_W];
         old_short = stats_rd_ff[CNT_W+2*TIME_W-1:CNT_W+TIME_W];
         old_long  = stats_rd_ff[CNT_W+3*TIME_W-1:CNT_W+2*TIME_W];
      end else begin
         old_count = '0;
         old_total = '0;
         old_short = TIME_MAX;
         old_long  = '0;
      end
      sum      = {1'b0, old_total} + elapsed_ff;
      total_in = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      count_in = (old_count == CNT_MAX) ? old_count : old_count + CNT_W'(1);
      short_in = (elapsed_ff[TIME_W-1:0] < old_short) ? elapsed_ff[TIME_W-1:0] : old_short;
      long_in  = (elapsed_ff[TIME_W-1:0] > old_long) ? elapsed_ff[TIME_W-1:0] : old_long;
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         res_cpu_ff      <= cpu_ff;
         res_state_ff    <= slot_state_ff;
         res_interval_ff <= elapsed_ff[TIME_W-1:0];
         res_count_ff    <= count_in;
         res_total_ff    <= total_in;
         res_short_ff    <= short_in;
         res_long_ff     <= long_in;
      end
   end

   isr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (res_total_ff),
      .divisor  (res_count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {2'b00, quotient, res_long_ff, res_short_ff, res_total_ff,
                         res_count_ff, res_interval_ff, res_state_ff, res_cpu_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/isr_ctrl.sv
// ----------------------------------------------------------------------------
// isr_ctrl
// sequencing state machine: decode, slot read, update, division and
// hand-off to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module isr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output isr_pkg::isr_cmd_type      cmd,
   input  wire isr_pkg::isr_sts_type sts
);
   import isr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_ELAPSED,
      ST_UPDATE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (sts.cpu_ok) begin
               if (!sts.is_exit) begin
                  cmd.ent_write = sts.state_ok;
               end else if (sts.open_ok) begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.calc = 1'b1;
            state_in = ST_ELAPSED;
         end
         ST_ELAPSED: begin
            // an exit before its entry leaves the state open
            if (sts.negative) begin
               state_in = ST_IDLE;
            end else begin
               cmd.upd  = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

>>> rtl/core/idle_state_residency_stats_core.sv
// ----------------------------------------------------------------------------
// idle_state_residency_stats_core
// per-cpu, per-idle-state residency statistics from idle entry/exit beats
// ----------------------------------------------------------------------------
// One request beat is taken at a time. An entry beat, or an exit beat that is
// dropped at decode, leaves the decode state before the next beat can be
// accepted. An exit whose time lies before the entry time is dropped after the
// slot read and the elapsed-time step. An exit that closes an interval reads
// its slot, forms the elapsed time, updates the statistics and runs the serial
// divider that forms the mean, one quotient bit per cycle, before its result is
// handed to the output register; the hand-off waits while an earlier result is
// still not taken on rsp_, and the next beat can be accepted in the cycle after
// it. The result waits in its own register, so the next request is accepted
// while it is still pending on rsp_. Statistics memories need no clearing pass
// after reset: a valid bit per slot stands in for it.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_state_residency_stats_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: cpu_number[2:0], idle_state[5:3], timestamp_us[53:6], zero pad
   input  wire logic [isr_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation (0 enter, 1 exit)
   input  wire logic                           req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata: stat_cpu[2:0], stat_state[5:3], interval_us[53:6],
   //        hit_count[85:54], total_us[133:86], shortest_us[181:134],
   //        longest_us[229:182], mean_us[277:230], zero pad
   output logic [isr_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import isr_pkg::*;

   isr_cmd_type cmd;
   isr_sts_type sts;

   isr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   isr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
